/* hdl/gaussian_mixture_background_pixel_assert.svh */
// Assertion macros shared by the background pixel classifier modules.
`ifndef GAUSSIAN_MIXTURE_BACKGROUND_PIXEL_ASSERT_SVH
`define GAUSSIAN_MIXTURE_BACKGROUND_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define GMB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// A condition that must hold in the same cycle as its trigger.
`define GMB_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// A condition that must hold in the cycle after its trigger.
`define GMB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GMB_ASSERT(name, prop)
`define GMB_ASSERT_IMPL(name, ante, cons)
`define GMB_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* hdl/gmb_pkg.sv */
// Types, constants and helper functions of the background pixel classifier.
`timescale 1ns / 1ps
package gmb_pkg;

  // Model size.
  localparam int MODES  = 10;
  localparam int PIXELS = 65536;
  localparam int ADDR_W = 16;
  localparam int MODE_W = 4;

  // Field widths.
  localparam int MEAN_W   = 18;
  localparam int SIGMA_W  = 16;
  localparam int WEIGHT_W = 14;
  localparam int CD_W     = 7;

  // Arithmetic constants.
  localparam int AVG_WEIGHT   = 10000 / MODES;
  localparam int WEIGHT_MAX   = 16383;
  localparam int WEIGHT_DEC   = 2;
  localparam int WEIGHT_GAIN  = 2 * MODES;
  localparam int MEAN_MAX     = 131071;
  localparam int MEAN_MIN     = -131072;
  localparam int SIGMA_MAX    = 65535;
  localparam int SIGMA_STEP   = 10;
  localparam int STEP_BASE    = 5;
  localparam int SCALE_TOTAL  = 10000;
  localparam int VALUE_SCALE  = 100;
  localparam int MEAN_SPAN    = 25500;
  localparam int RESET_SIGMA  = 1000;
  localparam int RESET_CD     = 20;

  // Mean step division by 30000: floor(x / 30000) equals floor(floor(x / 16) / 1875), and
  // the reciprocal ceil(2^33 / 1875) gives the exact quotient for every x below 2^26.
  localparam int STEP_PRE_SH   = 4;
  localparam int STEP_RECIP    = 4581299;
  localparam int STEP_RECIP_SH = 33;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIGHT_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_FLOOR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_INIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FLOOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RENORM_INTERVAL = 3'd5;
  localparam int CFG_DATA_W = 16;

  // Iterative divider geometry: the quotient always fits DIV_QW bits.
  localparam int DIV_QW    = 14;
  localparam int DIV_NW    = 28;
  localparam int DIV_DW    = 18;
  localparam int DIV_CNT_W = 4;

  typedef logic signed [MEAN_W-1:0] mean_t;
  typedef logic [SIGMA_W-1:0] sigma_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  // One memory row holds every mode of a pixel.
  typedef struct packed {
    mean_t   [MODES-1:0] mean;
    sigma_t  [MODES-1:0] sigma;
    weight_t [MODES-1:0] weight;
    logic    [CD_W-1:0]  countdown;
    logic    [MODE_W-1:0] ptr;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic [1:0] {
    DIV_DIST,
    DIV_SCALE
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accept;
    logic              load;
    logic              scan_mul;
    logic              div_start;
    div_sel_e          div_sel;
    logic              d_latch;
    logic              mul2;
    logic              step_latch;
    logic              update;
    logic              rotate;
    logic              replace;
    logic              floor_acc;
    logic              scale_write;
    logic              swap_rot;
    logic              ram_we;
    logic              clear_we;
    logic [ADDR_W-1:0] clear_addr;
    logic              out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic pos_last;
    logic pos_zero;
    logic pos_at_start;
    logic head_free;
    logic renorm;
    logic sum_zero;
    logic div_done;
    logic div_busy;
    logic out_free;
  } sts_t;

  // A sigma register of zero acts as one.
  function automatic sigma_t at_least_one(input sigma_t v);
    return (v == '0) ? sigma_t'(1) : v;
  endfunction

  // Contents of a pixel row after reset.
  function automatic row_t reset_row();
    row_t r;
    for (int k = 0; k < MODES; k++) begin
      r.mean[k]   = MEAN_W'(MEAN_SPAN * k / MODES);
      r.sigma[k]  = SIGMA_W'(RESET_SIGMA);
      r.weight[k] = WEIGHT_W'(AVG_WEIGHT);
    end
    r.countdown = CD_W'(RESET_CD);
    r.ptr       = '0;
    return r;
  endfunction

endpackage

/* hdl/gaussian_mixture_background_pixel.sv */
// Top level of the per-pixel mixture-of-Gaussians background classifier.
// A matching item scans the modes from the head, in a multiply state and a compare state per
// mode, and then runs one 14-step distance division. A renormalizing item adds one division
// per mode, unless the weight sum is zero. One item is in work at a time, and the next
// transfer is taken once the result is loaded into the output register. After reset every
// row of the pixel memory is cleared before the first transfer; configuration writes are
// taken always.
`timescale 1ns / 1ps
module gaussian_mixture_background_pixel (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [15:0]                    pixel_index_i,
  input  logic [7:0]                     pixel_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           is_background_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gmb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gmb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gmb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Configuration writes are always accepted.
  assign cfg_ready_o = 1'b1;

  gmb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gmb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pixel_index_i  (pixel_index_i),
    .pixel_value_i  (pixel_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .is_background_o(is_background_o)
  );

endmodule

/* hdl/gmb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/gmb_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module gmb_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [gmb_pkg::DIV_NW-1:0] num_i,
  input  logic [gmb_pkg::DIV_DW-1:0] den_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [gmb_pkg::DIV_QW-1:0] quot_o
);
  import gmb_pkg::*;

  logic [DIV_DW-1:0]    rem_q, rem_d;
  logic [DIV_QW-1:0]    quo_q, quo_d;
  logic [DIV_DW-1:0]    den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_DW:0]      trial;
  logic                 ge;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_q, quo_q[DIV_QW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DIV_DW'(trial - {1'b0, den_q}) : DIV_DW'(trial);
    quo_d = {quo_q[DIV_QW-2:0], ge};
  end

  // Control: busy flag, step counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DIV_DW'(num_i[DIV_NW-1:DIV_QW]);
      quo_q <= num_i[DIV_QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* hdl/gmb_datapath.sv */
// Datapath: pixel memory, mode registers, arithmetic and configuration registers.
`timescale 1ns / 1ps
`include "gaussian_mixture_background_pixel_assert.svh"
module gmb_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [gmb_pkg::ADDR_W-1:0]      pixel_index_i,
  input  logic [7:0]                      pixel_value_i,
  input  logic                            cfg_valid_i,
  input  logic [gmb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gmb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  gmb_pkg::cmd_t                   cmd_i,
  output gmb_pkg::sts_t                   sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            is_background_o
);
  import gmb_pkg::*;

  // Configuration registers.
  logic [9:0]          match_limit_q, tight_limit_q;
  sigma_t              sigma_floor_q, sigma_init_q;
  weight_t             weight_floor_q;
  logic [CD_W-1:0]     renorm_interval_q;

  // Working copy of one pixel row.
  mean_t               mean_q   [MODES];
  mean_t               mean_d   [MODES];
  sigma_t              sigma_q  [MODES];
  sigma_t              sigma_d  [MODES];
  weight_t             weight_q [MODES];
  weight_t             weight_d [MODES];
  logic [CD_W-1:0]     cd_q, cd_d;
  logic [MODE_W-1:0]   ptr_q, ptr_d;
  logic [MODE_W-1:0]   pos_q, pos_d;
  logic [ADDR_W-1:0]   addr_q;
  logic [7:0]          value_q;

  // Intermediate registers.
  logic [24:0]         ad100_q;
  logic [26:0]         lim_q;
  logic [9:0]          d_q;
  logic [25:0]         prod_q;
  logic [11:0]         step_q;
  logic [17:0]         sum_q, sum_d;
  logic                renorm_q, renorm_d;
  logic                bg_q, bg_d;
  logic                out_valid_q, is_bg_q;

  // Memory and divider signals.
  logic [ROW_W-1:0]    ram_rdata;
  row_t                rd_row, wr_row;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [DIV_NW-1:0]   div_num;
  logic [DIV_DW-1:0]   div_den;
  logic                div_busy, div_done;
  logic [DIV_QW-1:0]   div_quot;

  // Head mode arithmetic.
  sigma_t              s_head, floor_s, init_s, s_shrink;
  logic [16:0]         s_grow;
  logic [14:0]         v100;
  logic signed [18:0]  diff, m_ext, m_new, step_s;
  logic [17:0]         ad;
  logic [12:0]         step;
  logic [21:0]         step_y;
  logic [44:0]         step_prod;
  logic [14:0]         w_inc;
  weight_t             w_head, fw, x;
  mean_t               h0_m, h1_m;
  sigma_t              h0_s, h1_s;
  weight_t             h0_w, h1_w;
  logic                swap_c;

  // Per-pixel state memory.
  gmb_ram #(
    .WIDTH(ROW_W),
    .DEPTH(PIXELS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_we && cmd_i.clear_we ? reset_row() : wr_row),
    .raddr_i(pixel_index_i),
    .rdata_o(ram_rdata)
  );

  // Shared divider for the distance and the weight scaling.
  gmb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign rd_row    = row_t'(ram_rdata);
  assign ram_we    = cmd_i.ram_we || cmd_i.clear_we;
  assign ram_waddr = cmd_i.clear_we ? cmd_i.clear_addr : addr_q;

  // Pack the working registers into a row.
  always_comb begin
    for (int k = 0; k < MODES; k++) begin
      wr_row.mean[k]   = mean_q[k];
      wr_row.sigma[k]  = sigma_q[k];
      wr_row.weight[k] = weight_q[k];
    end
    wr_row.countdown = cd_q;
    wr_row.ptr       = ptr_q;
  end

  // Distance terms of the head mode.
  always_comb begin
    s_head  = at_least_one(sigma_q[0]);
    floor_s = at_least_one(sigma_floor_q);
    init_s  = at_least_one(sigma_init_q);
    v100    = 15'(value_q) * 15'(VALUE_SCALE);
    m_ext   = 19'(mean_q[0]);
    diff    = $signed({4'b0000, v100}) - m_ext;
    ad      = diff[18] ? 18'(-diff) : 18'(diff);
  end

  // Divider operand selection.
  always_comb begin
    case (cmd_i.div_sel)
      DIV_DIST: begin
        div_num = DIV_NW'(ad100_q);
        div_den = DIV_DW'(s_head);
      end
      DIV_SCALE: begin
        div_num = DIV_NW'(weight_q[0]) * DIV_NW'(SCALE_TOTAL);
        div_den = DIV_DW'(sum_q);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  // Mean step quotient by reciprocal multiplication.
  always_comb begin
    step_y    = prod_q[25:STEP_PRE_SH];
    step_prod = 45'(step_y) * 45'(STEP_RECIP);
  end

  // Update values of a matched head mode.
  always_comb begin
    step   = 13'(STEP_BASE) + 13'(step_q);
    step_s = $signed({6'b000000, step});
    m_new  = diff[18] ? m_ext - step_s : m_ext + step_s;
    if (m_new > 19'(MEAN_MAX)) begin
      m_new = 19'(MEAN_MAX);
    end else if (m_new < 19'(MEAN_MIN)) begin
      m_new = 19'(MEAN_MIN);
    end
    s_shrink = (s_head > sigma_t'(SIGMA_STEP)) ? s_head - sigma_t'(SIGMA_STEP) : '0;
    if (s_shrink < floor_s) begin
      s_shrink = floor_s;
    end
    s_grow = 17'(s_head) + 17'(SIGMA_STEP);
    if (s_grow > 17'(SIGMA_MAX)) begin
      s_grow = 17'(SIGMA_MAX);
    end
    w_inc  = 15'(weight_q[0]) + 15'(WEIGHT_GAIN);
    w_head = (w_inc > 15'(WEIGHT_MAX)) ? weight_t'(WEIGHT_MAX) : weight_t'(w_inc);
    fw     = (weight_q[0] < weight_floor_q) ? weight_floor_q : weight_q[0];
  end

  // Next state of the working row.
  always_comb begin
    mean_d   = mean_q;
    sigma_d  = sigma_q;
    weight_d = weight_q;
    cd_d     = cd_q;
    ptr_d    = ptr_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    renorm_d = renorm_q;
    bg_d     = bg_q;
    x        = '0;
    h0_m     = mean_q[0];
    h0_s     = sigma_q[0];
    h0_w     = weight_q[0];
    h1_m     = mean_q[1];
    h1_s     = sigma_q[1];
    h1_w     = weight_q[1];
    swap_c   = (weight_q[1] > weight_t'(AVG_WEIGHT)) && (weight_q[0] < weight_q[1]);

    if (cmd_i.load) begin
      for (int k = 0; k < MODES; k++) begin
        mean_d[k]   = rd_row.mean[k];
        sigma_d[k]  = rd_row.sigma[k];
        weight_d[k] = rd_row.weight[k];
      end
      cd_d     = rd_row.countdown;
      ptr_d    = rd_row.ptr;
      pos_d    = '0;
      sum_d    = '0;
      renorm_d = 1'b0;
      bg_d     = 1'b0;
    end

    // Matched mode: mean, sigma, weights and renormalization countdown.
    if (cmd_i.update) begin
      mean_d[0]  = MEAN_W'(m_new);
      sigma_d[0] = (d_q < tight_limit_q) ? s_shrink : sigma_t'(s_grow);
      bg_d       = weight_q[0] >= weight_t'(AVG_WEIGHT);
      for (int k = 0; k < MODES; k++) begin
        x = (k == 0) ? w_head : weight_q[k];
        weight_d[k] = (x >= weight_t'(WEIGHT_DEC)) ? x - weight_t'(WEIGHT_DEC) : '0;
      end
      if (cd_q <= CD_W'(1)) begin
        renorm_d = 1'b1;
        cd_d     = renorm_interval_q;
      end else begin
        cd_d = cd_q - 1'b1;
      end
    end

    // No match: overwrite the head mode.
    if (cmd_i.replace) begin
      mean_d[0]  = MEAN_W'(v100);
      sigma_d[0] = init_s;
      ptr_d      = (pos_q == MODE_W'(MODES - 1)) ? '0 : pos_q + 1'b1;
    end

    // Head edits that travel with a rotation.
    if (cmd_i.floor_acc) begin
      h0_w  = fw;
      sum_d = sum_q + 18'(fw);
    end
    if (cmd_i.scale_write) begin
      h0_w = div_quot;
    end
    if (cmd_i.swap_rot && swap_c) begin
      h0_m = mean_q[1];
      h0_s = sigma_q[1];
      h0_w = weight_q[1];
      h1_m = mean_q[0];
      h1_s = sigma_q[0];
      h1_w = weight_q[0];
    end

    // Rotate the modes by one place toward the head.
    if (cmd_i.rotate || cmd_i.floor_acc || cmd_i.scale_write || cmd_i.swap_rot) begin
      for (int k = 0; k < MODES - 1; k++) begin
        mean_d[k]   = mean_q[k+1];
        sigma_d[k]  = sigma_q[k+1];
        weight_d[k] = weight_q[k+1];
      end
      mean_d[0]         = h1_m;
      sigma_d[0]        = h1_s;
      weight_d[0]       = h1_w;
      mean_d[MODES-1]   = h0_m;
      sigma_d[MODES-1]  = h0_s;
      weight_d[MODES-1] = h0_w;
      pos_d = (pos_q == MODE_W'(MODES - 1)) ? '0 : pos_q + 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mean_q    <= mean_d;
    sigma_q   <= sigma_d;
    weight_q  <= weight_d;
    cd_q      <= cd_d;
    ptr_q     <= ptr_d;
    sum_q     <= sum_d;
    bg_q      <= bg_d;
    if (cmd_i.accept) begin
      addr_q  <= pixel_index_i;
      value_q <= pixel_value_i;
    end
    if (cmd_i.scan_mul) begin
      ad100_q <= 25'(ad) * 25'(VALUE_SCALE);
      lim_q   <= (27'(match_limit_q) + 27'd1) * 27'(s_head);
    end
    if (cmd_i.d_latch) begin
      d_q <= div_quot[9:0];
    end
    if (cmd_i.mul2) begin
      prod_q <= 26'(s_head) * 26'(d_q);
    end
    if (cmd_i.step_latch) begin
      step_q <= step_prod[44:STEP_RECIP_SH];
    end
    if (cmd_i.out_load) begin
      is_bg_q <= bg_q;
    end
  end

  // Control registers: position, renormalization flag, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      renorm_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      renorm_q <= renorm_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_limit_q     <= 10'd258;
      tight_limit_q     <= 10'd60;
      sigma_floor_q     <= 16'd200;
      sigma_init_q      <= 16'd1000;
      weight_floor_q    <= 14'd120;
      renorm_interval_q <= 7'd20;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MATCH_LIMIT:     match_limit_q     <= cfg_data_i[9:0];
        CFG_TIGHT_LIMIT:     tight_limit_q     <= cfg_data_i[9:0];
        CFG_SIGMA_FLOOR:     sigma_floor_q     <= cfg_data_i;
        CFG_SIGMA_INIT:      sigma_init_q      <= cfg_data_i;
        CFG_WEIGHT_FLOOR:    weight_floor_q    <= cfg_data_i[13:0];
        CFG_RENORM_INTERVAL: renorm_interval_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Status to the controller.
  always_comb begin
    sts_o.match        = 27'(ad100_q) < lim_q;
    sts_o.pos_last     = pos_q == MODE_W'(MODES - 1);
    sts_o.pos_zero     = pos_q == '0;
    sts_o.pos_at_start = pos_q == ptr_q;
    sts_o.head_free    = weight_q[0] <= weight_t'(AVG_WEIGHT);
    sts_o.renorm       = renorm_q;
    sts_o.sum_zero     = sum_q == '0;
    sts_o.div_done     = div_done;
    sts_o.div_busy     = div_busy;
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign is_background_o = is_bg_q;

  `GMB_ASSERT(a_pos_range, pos_q < MODE_W'(MODES))
  `GMB_ASSERT_IMPL(a_scale_nonzero, cmd_i.div_start && cmd_i.div_sel == DIV_SCALE, sum_q != '0)
  `GMB_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready_i, out_valid_q && $stable(is_bg_q))

endmodule

/* hdl/gmb_ctrl.sv */
// Controller: sequences memory clearing, mode scan, update, replacement and renormalization.
`timescale 1ns / 1ps
`include "gaussian_mixture_background_pixel_assert.svh"
module gmb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gmb_pkg::sts_t sts_i,
  output gmb_pkg::cmd_t cmd_o
);
  import gmb_pkg::*;

  localparam logic [4:0] S_CLEAR      = 5'd0;
  localparam logic [4:0] S_IDLE       = 5'd1;
  localparam logic [4:0] S_LOAD       = 5'd2;
  localparam logic [4:0] S_SCAN_MUL   = 5'd3;
  localparam logic [4:0] S_SCAN_CMP   = 5'd4;
  localparam logic [4:0] S_DIV1       = 5'd5;
  localparam logic [4:0] S_MUL2       = 5'd6;
  localparam logic [4:0] S_STEP       = 5'd7;
  localparam logic [4:0] S_UPDATE     = 5'd8;
  localparam logic [4:0] S_ALIGN      = 5'd9;
  localparam logic [4:0] S_SEEK       = 5'd10;
  localparam logic [4:0] S_ROT_BACK   = 5'd11;
  localparam logic [4:0] S_FLOOR      = 5'd12;
  localparam logic [4:0] S_SCALE_CHK  = 5'd13;
  localparam logic [4:0] S_SCALE_DIV  = 5'd14;
  localparam logic [4:0] S_SCALE_WAIT = 5'd15;
  localparam logic [4:0] S_SWAP       = 5'd16;
  localparam logic [4:0] S_WRITE      = 5'd17;
  localparam logic [4:0] S_OUT        = 5'd18;

  logic [4:0]        state_q, state_d;
  logic [MODE_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  // Next state and command decode.
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    clr_d          = clr_q;
    cmd_o          = '0;
    cmd_o.div_sel  = DIV_DIST;
    cmd_o.clear_addr = clr_q;
    in_ready_o     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == ADDR_W'(PIXELS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_SCAN_MUL;
      end
      S_SCAN_MUL: begin
        cmd_o.scan_mul = 1'b1;
        state_d        = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts_i.match) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_DIST;
          state_d         = S_DIV1;
        end else begin
          cmd_o.rotate = 1'b1;
          state_d      = sts_i.pos_last ? S_ALIGN : S_SCAN_MUL;
        end
      end
      S_DIV1: begin
        cmd_o.div_sel = DIV_DIST;
        if (sts_i.div_done) begin
          cmd_o.d_latch = 1'b1;
          state_d       = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_STEP;
      end
      S_STEP: begin
        cmd_o.step_latch = 1'b1;
        state_d          = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_ROT_BACK;
      end
      S_ALIGN: begin
        cnt_d = '0;
        if (sts_i.pos_at_start) begin
          state_d = S_SEEK;
        end else begin
          cmd_o.rotate = 1'b1;
        end
      end
      S_SEEK: begin
        if (sts_i.head_free) begin
          cmd_o.replace = 1'b1;
          state_d       = S_ROT_BACK;
        end else if (cnt_q == MODE_W'(MODES - 1)) begin
          state_d = S_ROT_BACK;
        end else begin
          cmd_o.rotate = 1'b1;
          cnt_d        = cnt_q + 1'b1;
        end
      end
      S_ROT_BACK: begin
        if (sts_i.pos_zero) begin
          state_d = sts_i.renorm ? S_FLOOR : S_WRITE;
        end else begin
          cmd_o.rotate = 1'b1;
        end
      end
      S_FLOOR: begin
        cmd_o.floor_acc = 1'b1;
        if (sts_i.pos_last) begin
          state_d = S_SCALE_CHK;
        end
      end
      S_SCALE_CHK: begin
        state_d = sts_i.sum_zero ? S_SWAP : S_SCALE_DIV;
      end
      S_SCALE_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SCALE;
        state_d         = S_SCALE_WAIT;
      end
      S_SCALE_WAIT: begin
        cmd_o.div_sel = DIV_SCALE;
        if (sts_i.div_done) begin
          cmd_o.scale_write = 1'b1;
          state_d = sts_i.pos_last ? S_SWAP : S_SCALE_DIV;
        end
      end
      S_SWAP: begin
        if (sts_i.pos_last) begin
          cmd_o.rotate = 1'b1;
          state_d      = S_WRITE;
        end else begin
          cmd_o.swap_rot = 1'b1;
        end
      end
      S_WRITE: begin
        cmd_o.ram_we = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
    end
  end

  `GMB_ASSERT_NEXT(a_accept_load, in_valid_i && in_ready_o, state_q == S_LOAD)
  `GMB_ASSERT_IMPL(a_div_free, cmd_o.div_start, !sts_i.div_busy)
  `GMB_ASSERT_NEXT(a_write_out, state_q == S_WRITE, state_q == S_OUT)

endmodule
